// ===== sv/flpgc_pkg.sv =====
// Shared types, codes and reset values for the follower link parser and gap control.
// Used by every module of the block; depends on nothing else.
package flpgc_pkg;

	localparam int LINE_BUFFER_BYTES_DEF = 64;
	localparam int TIMER_BITS_DEF        = 16;

	localparam int DIST_W   = 10;
	localparam int BAND_W   = 8;
	localparam int TOUT_W   = 16;
	localparam int SPEED_W  = 8;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_TOO_CLOSE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_GAP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOST_TOUT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_SPEED = 3'd4;

	localparam logic [DIST_W-1:0]  TOO_CLOSE_RST   = 10'd10;
	localparam logic [DIST_W-1:0]  TARGET_GAP_RST  = 10'd30;
	localparam logic [BAND_W-1:0]  DEADBAND_RST    = 8'd5;
	localparam logic [TOUT_W-1:0]  LOST_TOUT_RST   = 16'd1000;
	localparam logic [SPEED_W-1:0] START_SPEED_RST = 8'd150;

	typedef enum logic [1:0] {
		KIND_BYTE   = 2'd0,
		KIND_UPDATE = 2'd1,
		KIND_TICK   = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ACT_NONE      = 4'd0,
		ACT_FWD       = 4'd1,
		ACT_BACK      = 4'd2,
		ACT_LEFT      = 4'd3,
		ACT_RIGHT     = 4'd4,
		ACT_FWDLEFT   = 4'd5,
		ACT_FWDRIGHT  = 4'd6,
		ACT_BACKLEFT  = 4'd7,
		ACT_BACKRIGHT = 4'd8,
		ACT_STOP      = 4'd9,
		ACT_BRAKE     = 4'd10
	} action_t;

	typedef enum logic [1:0] {
		EVT_NONE  = 2'd0,
		EVT_FOUND = 2'd1,
		EVT_LOST  = 2'd2
	} event_t;

	typedef enum logic [1:0] {
		LINE_NONE     = 2'd0,
		LINE_ACCEPTED = 2'd1,
		LINE_REJECTED = 2'd2
	} line_status_t;

	typedef struct packed {
		logic [DIST_W-1:0]  too_close_cm;
		logic [DIST_W-1:0]  target_gap_cm;
		logic [BAND_W-1:0]  deadband_cm;
		logic [TOUT_W-1:0]  lost_timeout_ms;
	} cfg_t;

	typedef struct packed {
		line_status_t       status;
		logic               accepted;
		action_t            leader_move;
		logic [SPEED_W-1:0] leader_speed;
	} parse_info_t;

	typedef struct packed {
		logic               link_lost;
		logic               lost_now;
		logic               found_now;
	} link_info_t;

	typedef struct packed {
		line_status_t       line_status;
		event_t             link_event;
		logic [SPEED_W-1:0] speed_value;
		logic               speed_write;
		action_t            motor_action;
	} result_t;

endpackage

// ===== sv/flpgc_line_parser.sv =====
// Line assembler and parser for received link bytes; holds the leader's move and speed.
// Depends on flpgc_pkg.
module flpgc_line_parser #(
	parameter int LINE_BUFFER_BYTES = flpgc_pkg::LINE_BUFFER_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             byte_en,
	input  logic [7:0]                       rx_byte,
	input  logic                             speed_we,
	input  logic [flpgc_pkg::SPEED_W-1:0]    speed_wdata,
	output flpgc_pkg::parse_info_t           info
);
	import flpgc_pkg::*;

	localparam int PW = $clog2(LINE_BUFFER_BYTES);
	localparam logic [PW-1:0] POS_LAST = PW'(LINE_BUFFER_BYTES - 1);

	logic [PW-1:0]      pos_q, pos_d;
	logic               header_ok_q, header_ok_d;
	action_t            pending_q, pending_d;
	logic [8:0]         acc_q, acc_d;
	logic               field_done_q, field_done_d;
	action_t            leader_move_q;
	logic [SPEED_W-1:0] leader_speed_q;
	logic               is_eol, accepted;
	logic [11:0]        acc_next;
	action_t            move;

	always_comb begin
		unique case (rx_byte)
			8'h46:   move = ACT_FWD;
			8'h42:   move = ACT_BACK;
			8'h4C:   move = ACT_LEFT;
			8'h52:   move = ACT_RIGHT;
			8'h47:   move = ACT_FWDLEFT;
			8'h48:   move = ACT_FWDRIGHT;
			8'h49:   move = ACT_BACKLEFT;
			8'h4A:   move = ACT_BACKRIGHT;
			8'h53:   move = ACT_STOP;
			default: move = ACT_NONE;
		endcase
	end

	assign is_eol   = (rx_byte == 8'h0A) || (rx_byte == 8'h0D);
	assign accepted = is_eol && (pos_q != '0) && header_ok_q && (pending_q != ACT_NONE);
	assign acc_next = 12'(acc_q) * 12'd10 + 12'(rx_byte - 8'h30);

	always_comb begin
		pos_d        = pos_q;
		header_ok_d  = header_ok_q;
		pending_d    = pending_q;
		acc_d        = acc_q;
		field_done_d = field_done_q;
		if (is_eol) begin
			pos_d = '0;
		end else if (pos_q < POS_LAST) begin
			pos_d = pos_q + PW'(1);
			if (pos_q == PW'(0)) begin
				header_ok_d  = (rx_byte == 8'h4C);
				pending_d    = ACT_NONE;
				acc_d        = '0;
				field_done_d = 1'b0;
			end else if (pos_q == PW'(1)) begin
				header_ok_d = header_ok_q && (rx_byte == 8'h46);
			end else if (pos_q == PW'(2)) begin
				header_ok_d = header_ok_q && (rx_byte == 8'h3A);
			end else if (pos_q == PW'(3)) begin
				pending_d = move;
			end else if (pos_q >= PW'(5) && !field_done_q) begin
				if (rx_byte == 8'h2C || rx_byte == 8'h00) begin
					field_done_d = 1'b1;
				end else if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
					acc_d = (acc_next > 12'd256) ? 9'd256 : acc_next[8:0];
				end
			end
		end else begin
			pos_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			header_ok_q    <= 1'b1;
			pending_q      <= ACT_NONE;
			acc_q          <= '0;
			field_done_q   <= 1'b0;
			leader_move_q  <= ACT_STOP;
			leader_speed_q <= START_SPEED_RST;
		end else begin
			if (byte_en) begin
				pos_q        <= pos_d;
				header_ok_q  <= header_ok_d;
				pending_q    <= pending_d;
				acc_q        <= acc_d;
				field_done_q <= field_done_d;
				if (accepted) begin
					leader_move_q <= pending_q;
					if (acc_q != 9'd0 && acc_q <= 9'd255) begin
						leader_speed_q <= acc_q[7:0];
					end
				end
			end
			if (speed_we) begin
				leader_speed_q <= speed_wdata;
			end
		end
	end

	always_comb begin
		info.accepted     = accepted;
		info.leader_move  = leader_move_q;
		info.leader_speed = leader_speed_q;
		if (!is_eol || pos_q == '0) begin
			info.status = LINE_NONE;
		end else if (accepted) begin
			info.status = LINE_ACCEPTED;
		end else begin
			info.status = LINE_REJECTED;
		end
	end

endmodule

// ===== sv/flpgc_link_watchdog.sv =====
// Millisecond watchdog that ages the link and reports lost and found events.
// Depends on flpgc_pkg.
module flpgc_link_watchdog #(
	parameter int TIMER_BITS = flpgc_pkg::TIMER_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick_en,
	input  logic                          line_ok_en,
	input  logic [flpgc_pkg::TOUT_W-1:0]  lost_timeout_ms,
	output flpgc_pkg::link_info_t         info
);
	import flpgc_pkg::*;

	localparam int CW = (TIMER_BITS > TOUT_W) ? TIMER_BITS : TOUT_W;

	logic [TIMER_BITS-1:0] ms_q, ms_inc;
	logic                  lost_q;

	assign ms_inc = (ms_q == '1) ? ms_q : ms_q + TIMER_BITS'(1);

	always_comb begin
		info.link_lost = lost_q;
		info.lost_now  = tick_en && !lost_q && (CW'(ms_inc) >= CW'(lost_timeout_ms));
		info.found_now = line_ok_en && lost_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q   <= '0;
			lost_q <= 1'b0;
		end else if (tick_en) begin
			ms_q <= ms_inc;
			if (info.lost_now) begin
				lost_q <= 1'b1;
			end
		end else if (line_ok_en) begin
			ms_q   <= '0;
			lost_q <= 1'b0;
		end
	end

endmodule

// ===== sv/flpgc_gap_ctrl.sv =====
// Gap control decision for one update: brake, back off, stop in the band or follow the leader.
// Stops when the link is lost. Depends on flpgc_pkg.
module flpgc_gap_ctrl (
	input  flpgc_pkg::cfg_t                 cfg,
	input  logic                            link_lost,
	input  logic [flpgc_pkg::DIST_W-1:0]    front_distance,
	input  logic                            distance_valid,
	input  flpgc_pkg::action_t              leader_move,
	input  logic [flpgc_pkg::SPEED_W-1:0]   leader_speed,
	output flpgc_pkg::action_t              motor_action,
	output logic                            speed_write,
	output logic [flpgc_pkg::SPEED_W-1:0]   speed_value
);
	import flpgc_pkg::*;

	logic signed [11:0] dist_s, lower, upper;

	assign dist_s = $signed({2'b00, front_distance});
	assign lower  = $signed({2'b00, cfg.target_gap_cm}) - $signed({4'b0000, cfg.deadband_cm});
	assign upper  = $signed({2'b00, cfg.target_gap_cm}) + $signed({4'b0000, cfg.deadband_cm});

	always_comb begin
		motor_action = leader_move;
		speed_write  = 1'b1;
		speed_value  = leader_speed;
		if (link_lost) begin
			motor_action = ACT_STOP;
			speed_write  = 1'b0;
			speed_value  = '0;
		end else if (distance_valid) begin
			priority if (front_distance <= cfg.too_close_cm) begin
				motor_action = ACT_BRAKE;
				speed_write  = 1'b0;
				speed_value  = '0;
			end else if (dist_s < lower) begin
				motor_action = ACT_BACK;
				speed_write  = 1'b0;
				speed_value  = '0;
			end else if (dist_s <= upper) begin
				motor_action = ACT_STOP;
				speed_write  = 1'b0;
				speed_value  = '0;
			end else begin
				motor_action = leader_move;
			end
		end
	end

endmodule

// ===== sv/follower_link_parser_gap_control.sv =====
// Follower side of a leader-follower link: the input register, the result register and config.
// Depends on flpgc_pkg, flpgc_line_parser, flpgc_link_watchdog and flpgc_gap_ctrl.
//
// Items arrive on the s_ stream: tuser carries the kind (received byte, control update or
// millisecond tick) and tdata the byte, the front distance and its valid flag. Every item
// gives exactly one result on the m_ stream with the motor action, the speed write, the
// link event and the line status.
// An accepted request is registered in the input register, worked through combinationally and
// lands in the result register once that register is free or being taken; a stalled receiver holds it back.
// One request is taken in every cycle while the receiver keeps up; the single result register is
// the only output buffer, and the input register holds a request while a result waits.
// When the receiver stalls, the result is held and the input register fills; s_tready then
// falls until m_tready returns, and no request or result is lost.
// Configuration writes through cfg_we, cfg_index and cfg_data take effect at once; the user must
// make them while no request is in flight, as the block does not enforce it. Writing the start
// speed also loads the leader speed. Reset clears the line parser, sets the leader move to stop and the
// leader speed to the start speed, clears the watchdog, restores the register defaults and empties the pipeline.
module follower_link_parser_gap_control #(
	parameter int LINE_BUFFER_BYTES = flpgc_pkg::LINE_BUFFER_BYTES_DEF,
	parameter int TIMER_BITS        = flpgc_pkg::TIMER_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [23:0]                       s_tdata,  // rx_byte, front_distance, distance_valid
	input  logic [1:0]                        s_tuser,  // kind
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [23:0]                       m_tdata,  // motor_action, speed_write,
	                                                    // speed_value, link_event, line_status
	input  logic                              cfg_we,
	input  logic [flpgc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [flpgc_pkg::CFG_W-1:0]       cfg_data
);
	import flpgc_pkg::*;

	cfg_t               cfg_q;
	logic               valid_s1;
	kind_t              kind_s1;
	logic [7:0]         byte_s1;
	logic [DIST_W-1:0]  dist_s1;
	logic               seen_s1;
	logic               advance;
	result_t            res_d, res_q;
	logic               m_valid_q;
	parse_info_t        pinfo;
	link_info_t         linfo;
	action_t            gap_action;
	logic               gap_swrite;
	logic [SPEED_W-1:0] gap_sval;
	logic               speed_we;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign speed_we = cfg_we && (cfg_index == REG_START_SPEED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.too_close_cm    <= TOO_CLOSE_RST;
			cfg_q.target_gap_cm   <= TARGET_GAP_RST;
			cfg_q.deadband_cm     <= DEADBAND_RST;
			cfg_q.lost_timeout_ms <= LOST_TOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TOO_CLOSE:  cfg_q.too_close_cm    <= cfg_data[DIST_W-1:0];
				REG_TARGET_GAP: cfg_q.target_gap_cm   <= cfg_data[DIST_W-1:0];
				REG_DEADBAND:   cfg_q.deadband_cm     <= cfg_data[BAND_W-1:0];
				REG_LOST_TOUT:  cfg_q.lost_timeout_ms <= cfg_data[TOUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= kind_t'(s_tuser);
			byte_s1 <= s_tdata[7:0];
			dist_s1 <= s_tdata[17:8];
			seen_s1 <= s_tdata[18];
		end
	end

	flpgc_line_parser #(
		.LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_en     (advance && kind_s1 == KIND_BYTE),
		.rx_byte     (byte_s1),
		.speed_we    (speed_we),
		.speed_wdata (cfg_data[SPEED_W-1:0]),
		.info        (pinfo)
	);

	flpgc_link_watchdog #(
		.TIMER_BITS(TIMER_BITS)
	) u_watchdog (
		.clk             (clk),
		.arst_n          (arst_n),
		.tick_en         (advance && kind_s1 == KIND_TICK),
		.line_ok_en      (advance && kind_s1 == KIND_BYTE && pinfo.accepted),
		.lost_timeout_ms (cfg_q.lost_timeout_ms),
		.info            (linfo)
	);

	flpgc_gap_ctrl u_gap (
		.cfg            (cfg_q),
		.link_lost      (linfo.link_lost),
		.front_distance (dist_s1),
		.distance_valid (seen_s1),
		.leader_move    (pinfo.leader_move),
		.leader_speed   (pinfo.leader_speed),
		.motor_action   (gap_action),
		.speed_write    (gap_swrite),
		.speed_value    (gap_sval)
	);

	always_comb begin
		res_d = '{line_status: LINE_NONE, link_event: EVT_NONE, speed_value: '0,
			speed_write: 1'b0, motor_action: ACT_NONE};
		unique case (kind_s1)
			KIND_BYTE: begin
				res_d.line_status = pinfo.status;
				if (linfo.found_now) begin
					res_d.link_event = EVT_FOUND;
				end
			end
			KIND_UPDATE: begin
				res_d.motor_action = gap_action;
				res_d.speed_write  = gap_swrite;
				res_d.speed_value  = gap_sval;
			end
			KIND_TICK: begin
				if (linfo.lost_now) begin
					res_d.motor_action = ACT_STOP;
					res_d.link_event   = EVT_LOST;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'b0, res_q};

`ifndef ASSERT_OFF
	a_found_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.link_event == EVT_FOUND |-> res_q.line_status == LINE_ACCEPTED)
		else $error("found event without an accepted line");

	a_line_no_action: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.line_status != LINE_NONE |-> res_q.motor_action == ACT_NONE)
		else $error("line end result carries a motor action");

	a_write_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.speed_write |-> res_q.link_event == EVT_NONE)
		else $error("speed write together with a link event");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && m_valid_q && !m_tready)
		else $error("input stalled without a stalled result");

	a_lost_stops: assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind_s1 == KIND_UPDATE && linfo.link_lost |=> m_valid_q && !res_q.speed_write)
		else $error("speed written while the link is lost");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for follower_link_parser_gap_control: line parsing, lost-link watchdog
// and gap control, checked result by result against a predictor kept in this file.
// Depends on flpgc_pkg and the follower_link_parser_gap_control RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import flpgc_pkg::*;

	localparam logic [1:0] KIND_UNUSED      = 2'd3;
	localparam logic [7:0] CHAR_LF          = 8'h0A;
	localparam logic [7:0] CHAR_CR          = 8'h0D;
	localparam logic [7:0] CHAR_NUL         = 8'h00;
	localparam int         SPEED_OVER       = 256;
	localparam int         TIMER_TOP        = (1 << TIMER_BITS_DEF) - 1;
	localparam int         LONG_HOLD_AT     = 100;
	localparam int         LONG_HOLD_CYCLES = 250;
	localparam int         WATCH_TOUT_MS    = 40;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] rx_byte;
		logic [9:0] front_distance;
		logic       distance_valid;
		logic [4:0] gap;
	} link_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [23:0]          s_tdata = '0;
	logic [1:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [23:0]          m_tdata;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	link_item_t link_items_q[$];
	result_t    follower_results_q[$];
	logic [7:0] line_buf[$];
	int         items_pushed = 0;
	int         errors = 0;
	bit         tx_calm = 1'b0;
	bit         rx_calm = 1'b0;

	// Predictor state and register copies.
	logic [DIST_W-1:0]  cfg_too_close;
	logic [DIST_W-1:0]  cfg_target;
	logic [BAND_W-1:0]  cfg_band;
	logic [TOUT_W-1:0]  cfg_timeout;
	logic [SPEED_W-1:0] cfg_start;
	int                 line_pos;
	bit                 hdr_ok;
	action_t            pend_move;
	int                 spd_acc;
	bit                 spd_done;
	action_t            ldr_move;
	logic [SPEED_W-1:0] ldr_speed;
	int                 ms_count;
	bit                 link_lost;

	int                 tx_wait = 0;
	bit                 gap_done = 1'b0;
	link_item_t         tx_next;
	int                 rx_wait = 0;
	int                 rx_draw;
	int                 results_seen = 0;
	result_t            mon_got;
	result_t            mon_want;

	follower_link_parser_gap_control DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic action_t move_code(input logic [7:0] b);
		case (b)
			"F": return ACT_FWD;
			"B": return ACT_BACK;
			"L": return ACT_LEFT;
			"R": return ACT_RIGHT;
			"G": return ACT_FWDLEFT;
			"H": return ACT_FWDRIGHT;
			"I": return ACT_BACKLEFT;
			"J": return ACT_BACKRIGHT;
			"S": return ACT_STOP;
			default: return ACT_NONE;
		endcase
	endfunction

	function automatic result_t follower_step(input logic [1:0] k, input logic [7:0] b,
			input logic [9:0] d, input logic v);
		result_t r;
		int      lower;
		int      upper;
		bit      follow;
		r = '0;
		if (k == KIND_BYTE) begin
			if (b == CHAR_LF || b == CHAR_CR) begin
				if (line_pos > 0) begin
					if (hdr_ok && pend_move != ACT_NONE) begin
						r.line_status = LINE_ACCEPTED;
						ldr_move = pend_move;
						if (spd_acc > 0 && spd_acc <= 255)
							ldr_speed = spd_acc[7:0];
						ms_count = 0;
						if (link_lost) begin
							link_lost = 1'b0;
							r.link_event = EVT_FOUND;
						end
					end else begin
						r.line_status = LINE_REJECTED;
					end
					line_pos = 0;
				end
			end else if (line_pos < LINE_BUFFER_BYTES_DEF - 1) begin
				if (line_pos == 0) begin
					hdr_ok = (b == "L");
					pend_move = ACT_NONE;
					spd_acc = 0;
					spd_done = 1'b0;
				end else if (line_pos == 1) begin
					hdr_ok = hdr_ok && (b == "F");
				end else if (line_pos == 2) begin
					hdr_ok = hdr_ok && (b == ":");
				end else if (line_pos == 3) begin
					pend_move = move_code(b);
				end else if (line_pos >= 5 && !spd_done) begin
					if (b == "," || b == CHAR_NUL) begin
						spd_done = 1'b1;
					end else if (b >= "0" && b <= "9") begin
						spd_acc = spd_acc * 10 + (int'(b) - 48);
						if (spd_acc > SPEED_OVER)
							spd_acc = SPEED_OVER;
					end
				end
				line_pos++;
			end else begin
				line_pos = 0;
			end
		end else if (k == KIND_TICK) begin
			if (ms_count < TIMER_TOP)
				ms_count++;
			if (!link_lost && ms_count >= int'(cfg_timeout)) begin
				link_lost = 1'b1;
				r.motor_action = ACT_STOP;
				r.link_event = EVT_LOST;
			end
		end else if (k == KIND_UPDATE) begin
			if (link_lost) begin
				r.motor_action = ACT_STOP;
			end else begin
				follow = 1'b1;
				if (v) begin
					lower = int'(cfg_target) - int'(cfg_band);
					upper = int'(cfg_target) + int'(cfg_band);
					follow = 1'b0;
					if (int'(d) <= int'(cfg_too_close))
						r.motor_action = ACT_BRAKE;
					else if (int'(d) < lower)
						r.motor_action = ACT_BACK;
					else if (int'(d) <= upper)
						r.motor_action = ACT_STOP;
					else
						follow = 1'b1;
				end
				if (follow) begin
					r.motor_action = ldr_move;
					r.speed_write = 1'b1;
					r.speed_value = ldr_speed;
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// Sender: every request waits out its own gap before it is offered.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			tx_wait <= 0;
			gap_done <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				follower_results_q.push_back(follower_step(s_tuser, s_tdata[7:0],
					s_tdata[17:8], s_tdata[18]));
			if (!s_tvalid || s_tready) begin
				if (tx_wait > 0) begin
					s_tvalid <= 1'b0;
					tx_wait <= tx_wait - 1;
				end else if (link_items_q.size() > 0) begin
					tx_next = link_items_q[0];
					if (tx_next.gap != 0 && !gap_done) begin
						s_tvalid <= 1'b0;
						tx_wait <= int'(tx_next.gap) - 1;
						gap_done <= 1'b1;
					end else begin
						void'(link_items_q.pop_front());
						s_tvalid <= 1'b1;
						s_tuser <= tx_next.kind;
						s_tdata <= {5'b0, tx_next.distance_valid, tx_next.front_distance,
							tx_next.rx_byte};
						gap_done <= 1'b0;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, and one long hold-off that backs the block up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait <= 0;
			results_seen <= 0;
		end else if (m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			rx_draw = rx_calm ? 0 : $urandom_range(0, 19);
			if (results_seen + 1 == LONG_HOLD_AT)
				rx_draw = LONG_HOLD_CYCLES;
			if (rx_draw == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				rx_wait <= rx_draw;
			end
		end else if (!m_tready) begin
			if (rx_wait <= 1) begin
				m_tready <= 1'b1;
				rx_wait <= 0;
			end else begin
				rx_wait <= rx_wait - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			mon_got = result_t'(m_tdata[16:0]);
			if (follower_results_q.size() == 0) begin
				report_mismatch("result with no request pending", int'(m_tdata), 0);
			end else begin
				mon_want = follower_results_q.pop_front();
				if (mon_got.motor_action !== mon_want.motor_action)
					report_mismatch("motor_action", mon_got.motor_action, mon_want.motor_action);
				if (mon_got.speed_write !== mon_want.speed_write)
					report_mismatch("speed_write", mon_got.speed_write, mon_want.speed_write);
				if (mon_got.speed_value !== mon_want.speed_value)
					report_mismatch("speed_value", mon_got.speed_value, mon_want.speed_value);
				if (mon_got.link_event !== mon_want.link_event)
					report_mismatch("link_event", mon_got.link_event, mon_want.link_event);
				if (mon_got.line_status !== mon_want.line_status)
					report_mismatch("line_status", mon_got.line_status, mon_want.line_status);
			end
		end
	end

	task automatic push_item(input logic [1:0] k, input logic [7:0] b, input logic [9:0] d,
			input logic v);
		link_item_t it;
		it.kind = k;
		it.rx_byte = b;
		it.front_distance = d;
		it.distance_valid = v;
		it.gap = tx_calm ? 5'd0 : 5'($urandom_range(0, 19));
		link_items_q.push_back(it);
		items_pushed++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		push_item(KIND_BYTE, b, 10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
	endtask

	task automatic push_update(input logic [9:0] d, input logic v);
		push_item(KIND_UPDATE, 8'($urandom_range(0, 255)), d, v);
	endtask

	task automatic push_tick();
		push_item(KIND_TICK, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
			1'($urandom_range(0, 1)));
	endtask

	function automatic logic [7:0] term_byte();
		return $urandom_range(0, 1) ? CHAR_LF : CHAR_CR;
	endfunction

	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CHAR_LF || b == CHAR_CR);
		return b;
	endfunction

	function automatic logic [9:0] near_threshold();
		int t;
		case ($urandom_range(0, 3))
			0: t = int'(cfg_too_close);
			1: t = int'(cfg_target) - int'(cfg_band);
			2: t = int'(cfg_target) + int'(cfg_band);
			default: t = int'(cfg_target);
		endcase
		t = t + $urandom_range(0, 4) - 2;
		if (t < 0)
			t = 0;
		if (t > 1023)
			t = 1023;
		return 10'(t);
	endfunction

	task automatic load_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	task automatic flush_line();
		while (line_buf.size() > 0)
			push_byte(line_buf.pop_front());
	endtask

	task automatic build_good_line();
		string moves;
		string digits;
		int    n;
		moves = "FBLRGHIJS";
		line_buf = {};
		load_text("LF:");
		line_buf.push_back(moves[$urandom_range(0, 8)]);
		line_buf.push_back(($urandom_range(0, 9) < 7) ? 8'(",") : body_byte());
		case ($urandom_range(0, 9))
			0: n = 0;
			1: n = $urandom_range(256, 99999);
			2: n = $urandom_range(250, 260);
			default: n = $urandom_range(1, 255);
		endcase
		if ($urandom_range(0, 7) == 0)
			line_buf.push_back("0");
		digits = $sformatf("%0d", n);
		for (int i = 0; i < digits.len(); i++) begin
			if ($urandom_range(0, 11) == 0)
				line_buf.push_back(body_byte());
			line_buf.push_back(digits[i]);
		end
		if ($urandom_range(0, 1)) begin
			line_buf.push_back($urandom_range(0, 1) ? 8'(",") : CHAR_NUL);
			repeat ($urandom_range(0, 5))
				line_buf.push_back($urandom_range(0, 1) ? 8'($urandom_range(48, 57)) : body_byte());
		end
		line_buf.push_back(term_byte());
	endtask

	task automatic break_line();
		logic [7:0] b;
		int         keep;
		case ($urandom_range(0, 5))
			0: begin
				do b = body_byte(); while (b == "L");
				line_buf[0] = b;
			end
			1: begin
				do b = body_byte(); while (b == "F");
				line_buf[1] = b;
			end
			2: begin
				do b = body_byte(); while (b == ":");
				line_buf[2] = b;
			end
			3: begin
				do b = body_byte(); while (move_code(b) != ACT_NONE);
				line_buf[3] = b;
			end
			4: begin
				keep = $urandom_range(1, 3);
				while (line_buf.size() > keep)
					void'(line_buf.pop_back());
				line_buf.push_back(term_byte());
			end
			default: line_buf = {term_byte()};
		endcase
	endtask

	task automatic fill_random(input int n);
		int start;
		int pick;
		int len;
		start = items_pushed;
		while (items_pushed - start < n) begin
			if ($urandom_range(0, 6) == 0)
				tx_calm = !tx_calm;
			if ($urandom_range(0, 8) == 0)
				rx_calm = !rx_calm;
			pick = $urandom_range(0, 99);
			if (pick < 42) begin
				build_good_line();
				flush_line();
			end else if (pick < 55) begin
				build_good_line();
				break_line();
				flush_line();
			end else if (pick < 58) begin
				repeat (LINE_BUFFER_BYTES_DEF)
					push_byte(body_byte());
				build_good_line();
				flush_line();
			end else if (pick < 66) begin
				repeat ($urandom_range(1, 6))
					push_byte(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 1))
					push_byte(term_byte());
			end else if (pick < 84) begin
				repeat ($urandom_range(1, 4))
					push_update($urandom_range(0, 1) ? 10'($urandom_range(0, 1023))
						: near_threshold(), 1'($urandom_range(0, 3) != 0));
			end else if (pick < 98) begin
				len = (cfg_timeout <= 64) ? $urandom_range(1, int'(cfg_timeout) + 2)
					: $urandom_range(1, 20);
				repeat (len)
					push_tick();
			end else begin
				push_item(KIND_UNUSED, 8'($urandom_range(0, 255)),
					10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
			end
		end
		tx_calm = 1'b0;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (link_items_q.size() != 0 || s_tvalid || follower_results_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		case (idx)
			REG_TOO_CLOSE: cfg_too_close = DIST_W'(value);
			REG_TARGET_GAP: cfg_target = DIST_W'(value);
			REG_DEADBAND: cfg_band = BAND_W'(value);
			REG_LOST_TOUT: cfg_timeout = TOUT_W'(value);
			REG_START_SPEED: begin
				cfg_start = SPEED_W'(value);
				ldr_speed = cfg_start;
			end
			default: ;
		endcase
	endtask

	task automatic set_config(input int too_close, input int target, input int band,
			input int tout, input int speed);
		wait_idle();
		write_reg(REG_TOO_CLOSE, too_close);
		write_reg(REG_TARGET_GAP, target);
		write_reg(REG_DEADBAND, band);
		write_reg(REG_LOST_TOUT, tout);
		write_reg(REG_START_SPEED, speed);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		cfg_too_close = TOO_CLOSE_RST;
		cfg_target = TARGET_GAP_RST;
		cfg_band = DEADBAND_RST;
		cfg_timeout = LOST_TOUT_RST;
		cfg_start = START_SPEED_RST;
		line_pos = 0;
		hdr_ok = 1'b1;
		pend_move = ACT_NONE;
		spd_acc = 0;
		spd_done = 1'b0;
		ldr_move = ACT_STOP;
		ldr_speed = START_SPEED_RST;
		ms_count = 0;
		link_lost = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		push_item(KIND_UNUSED, 8'hFF, 10'h3FF, 1'b1);
		push_update(10'd0, 1'b0);
		push_update(10'd10, 1'b1);
		push_update(10'd11, 1'b1);
		push_update(10'd35, 1'b1);
		push_update(10'd36, 1'b1);
		load_text("LF:F,200");
		line_buf.push_back(CHAR_LF);
		flush_line();
		push_update(10'd1023, 1'b1);
		push_byte(CHAR_CR);
		load_text("LF");
		line_buf.push_back(CHAR_CR);
		flush_line();
		load_text("LF:R7999");
		line_buf.push_back(CHAR_LF);
		flush_line();
		load_text("LF:B,12");
		line_buf.push_back(CHAR_NUL);
		load_text("34");
		line_buf.push_back(CHAR_CR);
		flush_line();
		push_update(10'd500, 1'b0);
		push_tick();

		set_config(0, 0, 0, 1, 1);
		fill_random(130);

		// Run the timer straight up past the timeout with no gaps on either side.
		set_config(1023, 1023, 255, WATCH_TOUT_MS, 255);
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		repeat (WATCH_TOUT_MS + 2)
			push_tick();
		push_update(10'd1023, 1'b0);
		load_text("LF:S,255");
		line_buf.push_back(CHAR_LF);
		flush_line();
		tx_calm = 1'b0;
		wait_idle();
		rx_calm = 1'b0;
		fill_random(90);

		set_config(0, 0, 255, 2, $urandom_range(1, 255));
		fill_random(130);
		repeat (3) begin
			set_config($urandom_range(0, 200), $urandom_range(0, 400), $urandom_range(0, 60),
				$urandom_range(1, 60), $urandom_range(1, 255));
			fill_random(130);
		end

		wait_idle();
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#25_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
